/* rtl/seam_feather_blend_assert.svh */
// ----------------------------------------------------------------------------
// seam feather blend assertion macros
// shared concurrent check forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef SEAM_FEATHER_BLEND_ASSERT_SVH
`define SEAM_FEATHER_BLEND_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SFB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define SFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sfb_pkg.sv */
// ----------------------------------------------------------------------------
// sfb_pkg
// widths, codes and shared types of the seam feather blend
// ----------------------------------------------------------------------------
`default_nettype none

package sfb_pkg;

  localparam int PIX_W   = 8;   // bits per channel
  localparam int NUM_CH  = 3;   // channels per pixel, one lane each
  localparam int COL_W   = 13;  // column index and overlap start
  localparam int WIDTH_W = 14;  // reference width and overlap span
  localparam int NUM_W   = 22;  // blend numerator, 255 * span fits

  // lane stages: product, sum, then one quotient bit per stage
  localparam int LANE_STAGES = 2 + PIX_W;
  // input decode stage in front of the lanes
  localparam int NUM_STAGES  = 1 + LANE_STAGES;

  localparam int MAX_COLUMNS_DEF = 8192;
  localparam int WIDTH_RESET     = 8192;

  // register indexes of the configuration port
  localparam logic REG_OVERLAP_START   = 1'b0;
  localparam logic REG_REFERENCE_WIDTH = 1'b1;

  typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    MODE_REF,
    MODE_WARP,
    MODE_BLEND
  } mode_t;

  typedef struct packed {
    logic  load;
    mode_t mode;
  } merge_ctrl_t;

endpackage

`default_nettype wire

/* rtl/seam_feather_blend.sv */
// ----------------------------------------------------------------------------
// seam_feather_blend
// linear feather blend of reference and warped pixels across a stitch seam
// ----------------------------------------------------------------------------
// an accepted request passes through decode, product, sum, eight quotient bit
// stages and the output register
// throughput: one request per cycle unless stalled, set by the pipelined lanes
// a stage moves whenever some later stage or the output register has room
// reset: pipeline and output emptied, overlap_start 0, reference_width
// 8192 (or MAX_COLUMNS if smaller)
// ----------------------------------------------------------------------------
`default_nettype none

`include "seam_feather_blend_assert.svh"

module seam_feather_blend import sfb_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_wen,
  input  logic               cfg_index,
  input  logic [WIDTH_W-1:0] cfg_wdata,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COL_W-1:0]   column,
  input  logic [PIX_W-1:0]   ref_ch0,
  input  logic [PIX_W-1:0]   ref_ch1,
  input  logic [PIX_W-1:0]   ref_ch2,
  input  logic [PIX_W-1:0]   warp_ch0,
  input  logic [PIX_W-1:0]   warp_ch1,
  input  logic [PIX_W-1:0]   warp_ch2,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_ch0,
  output logic [PIX_W-1:0]   out_ch1,
  output logic [PIX_W-1:0]   out_ch2
);

  // reference width after reset, clipped to the column limit
  localparam logic [WIDTH_W-1:0] WidthRst =
    WIDTH_W'((MAX_COLUMNS < WIDTH_RESET) ? MAX_COLUMNS : WIDTH_RESET);

  // configuration registers
  logic [COL_W-1:0]   overlap_start;
  logic [WIDTH_W-1:0] reference_width;
  logic               width_sat;

  // written widths above the column limit saturate to it
  assign width_sat = {18'd0, cfg_wdata} > 32'(MAX_COLUMNS);

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_start   <= '0;
      reference_width <= WidthRst;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_OVERLAP_START:   overlap_start   <= cfg_wdata[COL_W-1:0];
        REG_REFERENCE_WIDTH: reference_width <= width_sat ? WIDTH_W'(MAX_COLUMNS)
                                                          : cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline occupancy and flow
  // free[s]: stage s may load this cycle, true when it or any later stage
  // is empty, or the output register is empty or being emptied
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] free;
  logic                  out_free;
  logic                  in_acc;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    for (int s = 0; s < NUM_STAGES; s++) begin
      free[s] = out_free;
      for (int t = s; t < NUM_STAGES; t++) begin
        if (!vld[t]) begin
          free[s] = 1'b1;
        end
      end
    end
  end

  assign in_ready = free[0];
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (free[0]) begin
        vld[0] <= in_acc;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (free[s]) begin
          vld[s] <= vld[s-1];
        end
      end
      if (out_free) begin
        out_valid <= vld[NUM_STAGES-1];
      end
    end
  end

  // request decode: the warped side wins over the reference side, so an
  // empty or inverted overlap never reaches the divider
  pix_t               ref_in;
  pix_t               warp_in;
  mode_t              mode_in;
  logic [WIDTH_W-1:0] span_in;    // reference_width - overlap_start
  logic [COL_W-1:0]   k_in;       // column - overlap_start
  logic [WIDTH_W-1:0] wk_in;      // reference_width - column

  assign ref_in  = {ref_ch2, ref_ch1, ref_ch0};
  assign warp_in = {warp_ch2, warp_ch1, warp_ch0};

  always_comb begin
    if ({1'b0, column} >= reference_width) begin
      mode_in = MODE_WARP;
    end else if (column < overlap_start || warp_in == '0) begin
      mode_in = MODE_REF;
    end else begin
      mode_in = MODE_BLEND;
    end
  end

  assign span_in = reference_width - {1'b0, overlap_start};
  assign k_in    = column - overlap_start;
  assign wk_in   = reference_width - {1'b0, column};

  // decode stage registers
  logic [WIDTH_W-1:0] w_s0;
  logic [COL_W-1:0]   k_s0;
  logic [WIDTH_W-1:0] wk_s0;

  // bypass pixels and mode travel alongside the lanes
  mode_t mode_q [NUM_STAGES];
  pix_t  ref_q  [NUM_STAGES];
  pix_t  warp_q [NUM_STAGES];

  always_ff @(posedge clk) begin
    if (free[0]) begin
      mode_q[0] <= mode_in;
      ref_q[0]  <= ref_in;
      warp_q[0] <= warp_in;
      w_s0      <= span_in;
      k_s0      <= k_in;
      wk_s0     <= wk_in;
    end
    for (int s = 1; s < NUM_STAGES; s++) begin
      if (free[s]) begin
        mode_q[s] <= mode_q[s-1];
        ref_q[s]  <= ref_q[s-1];
        warp_q[s] <= warp_q[s-1];
      end
    end
  end

  // one divider lane per channel
  pix_t blend_px;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    sfb_lane u_lane (
      .clk     (clk),
      .en      (free[NUM_STAGES-1:1]),
      .ref_px  (ref_q[0][c]),
      .warp_px (warp_q[0][c]),
      .w       (w_s0),
      .wk      (wk_s0),
      .k       (k_s0),
      .quo     (blend_px[c])
    );
  end

  // merge into the output register
  merge_ctrl_t mctrl;
  pix_t        out_px;

  assign mctrl.load = out_free;
  assign mctrl.mode = mode_q[NUM_STAGES-1];

  sfb_merge u_merge (
    .clk      (clk),
    .ctrl     (mctrl),
    .ref_px   (ref_q[NUM_STAGES-1]),
    .warp_px  (warp_q[NUM_STAGES-1]),
    .blend_px (blend_px),
    .out_px   (out_px)
  );

  assign out_ch0 = out_px[0];
  assign out_ch1 = out_px[1];
  assign out_ch2 = out_px[2];

  // back pressure only when every stage and the output register are held
  `SFB_ASSERT_IMPLY(a_stall_full, !in_ready, out_valid && !out_ready && (&vld), "stall with room in pipeline")
  // a blend always sees a nonzero span with k inside it
  `SFB_ASSERT_IMPLY(a_blend_span, vld[0] && mode_q[0] == MODE_BLEND, k_s0 < w_s0, "blend outside overlap span")
  // a new result comes only from an occupied last stage
  `SFB_ASSERT_IMPLY(a_no_invent, $rose(out_valid), $past(vld[NUM_STAGES-1]), "result without request")

endmodule

`default_nettype wire

/* rtl/sfb_lane.sv */
// ----------------------------------------------------------------------------
// sfb_lane
// one channel: weighted sum a*(w-k) + b*k, then restoring division by w,
// one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_lane import sfb_pkg::*; (
  input  logic                   clk,
  input  logic [LANE_STAGES-1:0] en,
  input  logic [PIX_W-1:0]       ref_px,
  input  logic [PIX_W-1:0]       warp_px,
  input  logic [WIDTH_W-1:0]     w,
  input  logic [WIDTH_W-1:0]     wk,
  input  logic [COL_W-1:0]       k,
  output logic [PIX_W-1:0]       quo
);

  logic [NUM_W-1:0]   prod_a;
  logic [NUM_W-1:0]   prod_b;
  logic [WIDTH_W-1:0] w_p;
  logic [NUM_W-1:0]   num;
  logic [WIDTH_W-1:0] w_n;

  logic [NUM_W-1:0]   rem_c [PIX_W+1];
  logic [WIDTH_W-1:0] wd_c  [PIX_W+1];
  logic [PIX_W-1:0]   q_c   [PIX_W+1];

  // products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_a <= NUM_W'(ref_px * wk);
      prod_b <= NUM_W'(warp_px * k);
      w_p    <= w;
    end
  end

  // sum
  always_ff @(posedge clk) begin
    if (en[1]) begin
      num <= prod_a + prod_b;
      w_n <= w_p;
    end
  end

  assign rem_c[0] = num;
  assign wd_c[0]  = w_n;
  assign q_c[0]   = '0;

  for (genvar i = 0; i < PIX_W; i++) begin : g_step
    localparam int Shift = PIX_W - 1 - i;
    logic [NUM_W-1:0]   trial;
    logic               ge;
    logic [NUM_W-1:0]   rem;
    logic [WIDTH_W-1:0] wd;
    logic [PIX_W-1:0]   q;

    assign trial = NUM_W'(wd_c[i]) << Shift;
    assign ge    = rem_c[i] >= trial;

    always_ff @(posedge clk) begin
      if (en[2+i]) begin
        rem <= ge ? rem_c[i] - trial : rem_c[i];
        wd  <= wd_c[i];
        q   <= {q_c[i][PIX_W-2:0], ge};
      end
    end

    assign rem_c[i+1] = rem;
    assign wd_c[i+1]  = wd;
    assign q_c[i+1]   = q;
  end

  assign quo = q_c[PIX_W];

endmodule

`default_nettype wire

/* rtl/sfb_merge.sv */
// ----------------------------------------------------------------------------
// sfb_merge
// picks reference, warped or blended pixel and holds it in the output register
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_merge import sfb_pkg::*; (
  input  logic        clk,
  input  merge_ctrl_t ctrl,
  input  pix_t        ref_px,
  input  pix_t        warp_px,
  input  pix_t        blend_px,
  output pix_t        out_px
);

  pix_t sel;

  always_comb begin
    case (ctrl.mode)
      MODE_WARP:  sel = warp_px;
      MODE_BLEND: sel = blend_px;
      MODE_REF:   sel = ref_px;
      default:    sel = ref_px;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_px <= sel;
    end
  end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: seam feather blend testbench
// drives pixel pair requests with random idling on both channels, predicts
// each blended pixel from a local copy of the overlap registers and checks
// every result in order against the queue of predicted pixels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import sfb_pkg::*; ();

  // pipeline stage count of the block, used to size the drain and quiet waits
  localparam int RESULT_LATENCY = NUM_STAGES;
  // cycles without any accepted request or result before giving up
  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int MAX_GAP        = 5;

  logic               clk;
  logic               rst;
  logic               cfg_wen;
  logic               cfg_index;
  logic [WIDTH_W-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [COL_W-1:0]   column;
  logic [PIX_W-1:0]   ref_ch0, ref_ch1, ref_ch2;
  logic [PIX_W-1:0]   warp_ch0, warp_ch1, warp_ch2;
  logic               out_valid;
  logic               out_ready;
  logic [PIX_W-1:0]   out_ch0, out_ch1, out_ch2;

  // local copy of the overlap registers, as the block holds them
  int unsigned seam_start;
  int unsigned seam_width;

  // blended pixels still to come, oldest first
  pix_t blended_fifo[$];

  // idling switches, flipped per phase so that stretches run without gaps
  bit send_gaps_on;
  bit recv_gaps_on;

  int unsigned pixels_sent;
  int unsigned pixels_checked;
  int unsigned mismatch_count;
  int unsigned reg_writes;
  int unsigned blend_hits;
  int unsigned stall_cycles;

  seam_feather_blend dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .column    (column),
    .ref_ch0   (ref_ch0),
    .ref_ch1   (ref_ch1),
    .ref_ch2   (ref_ch2),
    .warp_ch0  (warp_ch0),
    .warp_ch1  (warp_ch1),
    .warp_ch2  (warp_ch2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ch0   (out_ch0),
    .out_ch1   (out_ch1),
    .out_ch2   (out_ch2)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // feather blend of one pixel pair under the current overlap registers
  function automatic pix_t blend_pixel(logic [COL_W-1:0] col, pix_t ref_pix, pix_t warp_pix);
    pix_t        mixed;
    int unsigned span;
    int unsigned pos;
    // warped side is tested first, so it wins where an inverted overlap lets both apply
    if (col >= seam_width) begin
      mixed = warp_pix;
    end else if (col < seam_start || warp_pix == '0) begin
      mixed = ref_pix;
    end else begin
      span = seam_width - seam_start;
      pos  = col - seam_start;
      for (int c = 0; c < NUM_CH; c++) begin
        mixed[c] = PIX_W'((ref_pix[c] * (span - pos) + warp_pix[c] * pos) / span);
      end
    end
    return mixed;
  endfunction

  // wait until every predicted pixel has come back, then let the pipe empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (blended_fifo.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_register(input logic idx, input logic [WIDTH_W-1:0] value);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    if (idx == REG_OVERLAP_START) begin
      seam_start = value[COL_W-1:0];
    end else begin
      // widths beyond the column limit saturate
      seam_width = (value > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : value;
    end
    reg_writes++;
  endtask

  task automatic set_overlap(input int unsigned start, input int unsigned width);
    write_register(REG_OVERLAP_START, WIDTH_W'(start));
    write_register(REG_REFERENCE_WIDTH, WIDTH_W'(width));
  endtask

  // one pixel pair request; valid stays high afterwards for a back-to-back follower
  task automatic send_pixel(input logic [COL_W-1:0] col, input pix_t ref_pix,
                            input pix_t warp_pix);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    column   <= col;
    ref_ch0  <= ref_pix[0];
    ref_ch1  <= ref_pix[1];
    ref_ch2  <= ref_pix[2];
    warp_ch0 <= warp_pix[0];
    warp_ch1 <= warp_pix[1];
    warp_ch2 <= warp_pix[2];
    do @(posedge clk); while (!in_ready);
    if (col < seam_width && col >= seam_start && warp_pix != '0) blend_hits++;
    blended_fifo = {blended_fifo, blend_pixel(col, ref_pix, warp_pix)};
    pixels_sent++;
  endtask

  function automatic pix_t make_pix(input int unsigned c0, input int unsigned c1,
                                    input int unsigned c2);
    pix_t p;
    p[0] = PIX_W'(c0);
    p[1] = PIX_W'(c1);
    p[2] = PIX_W'(c2);
    return p;
  endfunction

  // channel value leaning on the extremes
  function automatic logic [PIX_W-1:0] pick_channel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom);
  endfunction

  // column mostly inside the overlap, some at its edges, some anywhere
  function automatic logic [COL_W-1:0] pick_column();
    int unsigned r;
    int          c;
    r = $urandom_range(0, 9);
    if (r < 6 && seam_width > seam_start) begin
      c = $urandom_range(seam_start, seam_width - 1);
    end else if (r == 6) begin
      c = int'(seam_start) + $urandom_range(0, 2) - 1;
    end else if (r == 7) begin
      c = int'(seam_width) + $urandom_range(0, 2) - 1;
    end else begin
      c = $urandom_range(0, (1 << COL_W) - 1);
    end
    if (c < 0) c = 0;
    if (c > (1 << COL_W) - 1) c = (1 << COL_W) - 1;
    return COL_W'(c);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, in-order comparison
  // ---------------------------------------------------------------------------
  task automatic check_channel(input int ch, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch out_ch%0d: expected %0d actual %0d", $realtime, ch, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : result_checker
    int   stall;
    pix_t want;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = recv_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (blended_fifo.size() == 0) begin
        $display("%0t unexpected result: expected none actual %0d %0d %0d",
                 $realtime, out_ch0, out_ch1, out_ch2);
        mismatch_count++;
      end else begin
        want = blended_fifo.pop_front();
        check_channel(0, want[0], out_ch0);
        check_channel(1, want[1], out_ch1);
        check_channel(2, want[2], out_ch2);
        pixels_checked++;
      end
    end
  end

  // watchdog: a long run of cycles with no request and no result accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no progress, %0d results outstanding",
               $realtime, blended_fifo.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: overlap spans the whole row, 0 to 8192
  task automatic test_reset_defaults();
    send_pixel(0,    make_pix(255, 255, 255), make_pix(0, 0, 1));
    send_pixel(8191, make_pix(0, 0, 0),       make_pix(255, 255, 255));
    send_pixel(4096, make_pix(10, 200, 255),  make_pix(250, 3, 0));
    send_pixel(8191, make_pix(255, 1, 128),   make_pix(0, 0, 0));
  endtask

  // each region and both edges of a plain overlap, plus the zero warp case
  task automatic test_overlap_regions();
    set_overlap(100, 200);
    send_pixel(99,   make_pix(1, 2, 3),       make_pix(200, 201, 202));
    send_pixel(100,  make_pix(255, 0, 77),    make_pix(0, 255, 77));
    send_pixel(150,  make_pix(255, 255, 255), make_pix(0, 1, 254));
    send_pixel(199,  make_pix(0, 128, 255),   make_pix(255, 128, 0));
    send_pixel(200,  make_pix(9, 9, 9),       make_pix(90, 91, 92));
    send_pixel(150,  make_pix(17, 34, 51),    make_pix(0, 0, 0));
    send_pixel(8191, make_pix(0, 0, 0),       make_pix(255, 255, 255));
  endtask

  // width written above the column limit saturates; overlap at the last column
  task automatic test_wide_width();
    set_overlap(8191, 16383);
    send_pixel(8190, make_pix(11, 22, 33),    make_pix(44, 55, 66));
    send_pixel(8191, make_pix(255, 0, 255),   make_pix(0, 255, 0));
    write_register(REG_REFERENCE_WIDTH, WIDTH_W'(8193));
    send_pixel(8191, make_pix(1, 1, 1),       make_pix(2, 2, 2));
  endtask

  // start beyond width: the warped side wins where both apply
  task automatic test_inverted_overlap();
    set_overlap(300, 200);
    send_pixel(250, make_pix(5, 6, 7),        make_pix(8, 9, 10));
    send_pixel(100, make_pix(5, 6, 7),        make_pix(8, 9, 10));
    send_pixel(350, make_pix(5, 6, 7),        make_pix(0, 0, 0));
  endtask

  // zero width: every column is on the warped side
  task automatic test_zero_width();
    set_overlap(0, 0);
    send_pixel(0,    make_pix(255, 255, 255), make_pix(0, 0, 0));
    send_pixel(5000, make_pix(1, 2, 3),       make_pix(4, 5, 6));
  endtask

  // random phases, each under a fresh overlap setting and idling mix
  task automatic test_random_blend();
    int unsigned target;
    int unsigned count;
    int unsigned start;
    int unsigned width;
    pix_t        ref_pix;
    pix_t        warp_pix;
    target = pixels_sent + RANDOM_ITEMS;
    while (pixels_sent < target) begin
      case ($urandom_range(0, 9))
        0: begin start = 0;    width = 8192; end
        1: begin start = 8191; width = 8192; end
        2: begin start = $urandom_range(0, 8191); width = $urandom_range(8193, 16383); end
        3: begin start = $urandom_range(1, 8191); width = $urandom_range(0, start); end
        4: begin start = $urandom_range(0, 8191); width = 0; end
        5: begin width = $urandom_range(1, 8192); start = width - 1; end
        6: begin start = $urandom_range(0, 4000); width = $urandom_range(start + 1, 8192); end
        default: begin
          start = $urandom_range(0, 8000);
          width = start + 1 + $urandom_range(0, 300);
        end
      endcase
      set_overlap(start, width);
      send_gaps_on = ($urandom_range(0, 3) != 0);
      recv_gaps_on = ($urandom_range(0, 3) != 0);
      count = $urandom_range(60, 200);
      // last phase stops at the item budget
      if (count > target - pixels_sent) count = target - pixels_sent;
      repeat (count) begin
        for (int c = 0; c < NUM_CH; c++) begin
          ref_pix[c]  = pick_channel();
          warp_pix[c] = pick_channel();
        end
        if ($urandom_range(0, 9) == 0) warp_pix = '0;
        send_pixel(pick_column(), ref_pix, warp_pix);
        // sender holds off now and then until everything has come back
        if ($urandom_range(0, 99) == 0) drain_results();
      end
    end
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          <= 1'b1;
    cfg_wen      <= 1'b0;
    cfg_index    <= REG_OVERLAP_START;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    column       <= '0;
    ref_ch0      <= '0;
    ref_ch1      <= '0;
    ref_ch2      <= '0;
    warp_ch0     <= '0;
    warp_ch1     <= '0;
    warp_ch2     <= '0;
    seam_start   = 0;
    seam_width   = (WIDTH_RESET > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : WIDTH_RESET;
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_overlap_regions();
    test_wide_width();
    test_inverted_overlap();
    test_zero_width();
    test_random_blend();

    // everything back, then a few quiet cycles to catch stray results
    drain_results();
    repeat (RESULT_LATENCY * 2) @(posedge clk);

    $display("covered %0d pixel pairs (%0d in the blend region) under %0d register writes",
             pixels_sent, blend_hits, reg_writes);
    $display("checked %0d results, %0d mismatches", pixels_checked, mismatch_count);
    if (mismatch_count == 0 && blended_fifo.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
